@@ design/sbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbpm_pkg
// Shared constants, codes and controller/datapath interface types for the
// seeded block permutation mapper.
// ----------------------------------------------------------------------------
package sbpm_pkg;

    // table geometry
    localparam int MAX_BLOCKS = 4096;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;

    // field widths
    localparam int SEED_W  = 32;
    localparam int SIDE_W  = 9;
    localparam int COORD_W = 20;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // lcg constants
    localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
    localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

    // divider geometry: full op takes the lcg value shifted right by one
    localparam int DIV_N     = SEED_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_N + 1);

    // opcodes
    localparam logic OPC_GENERATE = 1'b0;
    localparam logic OPC_LOOKUP   = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_READY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OUT_OF_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACROSS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 3'd4;

    // datapath commands
    typedef enum logic [4:0] {
        OP_NOP,
        OP_GEN_START,
        OP_LK_START,
        OP_FILL,
        OP_LCG,
        OP_DIV_J,
        OP_RD_I,
        OP_RD_J,
        OP_WR_I,
        OP_WR_J,
        OP_LK_MAP,
        OP_DIV_SRC,
        OP_SAVE_SRC,
        OP_DIV_DST,
        OP_SAVE_DST,
        OP_RES_GEN,
        OP_RES_NR,
        OP_RES_OOR,
        OP_RES_LOOK
    } dp_op_t;

    // datapath status back to the controller
    typedef struct packed {
        logic table_ready;
        logic idx_oor;
        logic fill_done;
        logic shuf_more;
        logic div_done;
    } dp_status_t;

endpackage

@@ design/sbpm_divider.sv @@
// ----------------------------------------------------------------------------
// sbpm_divider
// Restoring radix-2 divider, one quotient bit per cycle. A short op divides
// a block index in IDX_W steps; a full op divides a DIV_N bit value.
// ----------------------------------------------------------------------------
module sbpm_divider
    import sbpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 short_op,
    input  logic [DIV_N-1:0]     dividend,
    input  logic [CNT_W-1:0]     divisor,
    output logic                 done,
    output logic [DIV_N-1:0]     quot,
    output logic [CNT_W-1:0]     rem
);

    localparam int SHORT_SHIFT = DIV_N - IDX_W;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N-1:0]     q_reg;
    logic [CNT_W-1:0]     r_reg;
    logic [CNT_W-1:0]     d_reg;

    logic [CNT_W:0]       r_shift;
    logic [CNT_W:0]       r_diff;
    logic                 r_ge;

    // one restoring step
    assign r_shift = {r_reg, q_reg[DIV_N-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};
    assign r_ge    = (r_shift >= {1'b0, d_reg});

    // step counter and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_op ? DIV_CNT_W'(IDX_W) : DIV_CNT_W'(DIV_N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient and partial remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= short_op ? (dividend << SHORT_SHIFT) : dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[DIV_N-2:0], r_ge};
            r_reg <= r_ge ? r_diff[CNT_W-1:0] : r_shift[CNT_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

@@ design/sbpm_datapath.sv @@
// ----------------------------------------------------------------------------
// sbpm_datapath
// Configuration registers, permutation table memory, lcg, shared divider and
// coordinate multipliers, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module sbpm_datapath
    import sbpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_op_t                dp_cmd,
    output dp_status_t            dp_status,
    input  logic [IDX_W-1:0]      block_index,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [IDX_W-1:0]      src_index,
    output logic [IDX_W-1:0]      dst_index,
    output logic [COORD_W-1:0]    src_x,
    output logic [COORD_W-1:0]    src_y,
    output logic [COORD_W-1:0]    dst_x,
    output logic [COORD_W-1:0]    dst_y
);

    localparam int PROD_W = CNT_W + SIDE_W;

    // configuration and control state
    logic [SEED_W-1:0] seed_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  across_reg;
    logic [SIDE_W-1:0] side_reg;
    logic              decrypt_reg;
    logic              ready_reg;
    logic [SEED_W-1:0] lcg_reg;
    logic              done_reg;

    // working registers
    logic [CNT_W-1:0]   k_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   tmp_reg;
    logic [IDX_W-1:0]   src_reg;
    logic [IDX_W-1:0]   dst_reg;
    logic [COORD_W-1:0] sx_reg;
    logic [COORD_W-1:0] sy_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [STAT_W-1:0]  stat_out_reg;
    logic [IDX_W-1:0]   src_out_reg;
    logic [IDX_W-1:0]   dst_out_reg;
    logic [COORD_W-1:0] sx_out_reg;
    logic [COORD_W-1:0] sy_out_reg;
    logic [COORD_W-1:0] dx_out_reg;
    logic [COORD_W-1:0] dy_out_reg;

    // table memory
    logic [IDX_W-1:0] perm_mem [MAX_BLOCKS];
    logic [IDX_W-1:0] mem_rdata_reg;
    logic [IDX_W-1:0] mem_addr;
    logic [IDX_W-1:0] mem_wdata;
    logic             mem_we;

    // derived values
    logic [CNT_W-1:0]  n_eff;
    logic [CNT_W-1:0]  across_eff;
    logic [CNT_W-1:0]  i_val;
    logic [IDX_W-1:0]  j_val;
    logic [PROD_W-1:0] x_prod;
    logic [PROD_W-1:0] y_prod;
    logic              cfg_hit;

    // divider hookup
    logic              div_start;
    logic              div_short;
    logic [DIV_N-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic              div_done;
    logic [DIV_N-1:0]  div_quot;
    logic [CNT_W-1:0]  div_rem;

    assign n_eff      = (total_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_reg;
    assign across_eff = (across_reg == '0) ? CNT_W'(1) : across_reg;
    assign i_val      = k_reg - 1'b1;
    assign j_val      = div_rem[IDX_W-1:0];
    assign cfg_ready  = 1'b1;
    assign cfg_hit    = cfg_valid && (cfg_index <= CFG_DECRYPT);

    // coordinate products: column from remainder, row from quotient
    assign x_prod = PROD_W'(div_rem) * PROD_W'(side_reg);
    assign y_prod = PROD_W'(div_quot[IDX_W-1:0]) * PROD_W'(side_reg);

    // status to controller
    assign dp_status.table_ready = ready_reg;
    assign dp_status.idx_oor     = ({1'b0, block_index} >= n_eff);
    assign dp_status.fill_done   = (k_reg == n_eff);
    assign dp_status.shuf_more   = (k_reg > CNT_W'(1));
    assign dp_status.div_done    = div_done;

    // divider command
    always_comb
    begin
        div_start    = 1'b0;
        div_short    = 1'b1;
        div_dividend = DIV_N'(src_reg);
        div_divisor  = across_eff;
        case (dp_cmd)
            OP_DIV_J:
            begin
                div_start    = 1'b1;
                div_short    = 1'b0;
                div_dividend = lcg_reg[SEED_W-1:1];
                div_divisor  = k_reg;
            end
            OP_DIV_SRC:
            begin
                div_start = 1'b1;
            end
            OP_DIV_DST:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_N'(dst_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    sbpm_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .short_op (div_short),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // memory address and write select
    always_comb
    begin
        mem_addr  = block_index;
        mem_wdata = mem_rdata_reg;
        mem_we    = 1'b0;
        case (dp_cmd) inside
            OP_FILL:
            begin
                mem_addr  = k_reg[IDX_W-1:0];
                mem_wdata = k_reg[IDX_W-1:0];
                mem_we    = 1'b1;
            end
            OP_RD_I:
            begin
                mem_addr = i_val[IDX_W-1:0];
            end
            OP_WR_I:
            begin
                mem_addr = i_val[IDX_W-1:0];
                mem_we   = 1'b1;
            end
            OP_RD_J:
            begin
                mem_addr = j_val;
            end
            OP_WR_J:
            begin
                mem_addr  = j_val;
                mem_wdata = tmp_reg;
                mem_we    = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // single port table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= perm_mem[mem_addr];
    end

    // configuration, lcg, ready flag and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            total_reg   <= '0;
            across_reg  <= CNT_W'(1);
            side_reg    <= SIDE_W'(16);
            decrypt_reg <= 1'b0;
            ready_reg   <= 1'b0;
            lcg_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_hit)
            begin
                ready_reg <= 1'b0;
                unique case (cfg_index)
                    CFG_SEED:    seed_reg    <= cfg_data[SEED_W-1:0];
                    CFG_TOTAL:   total_reg   <= cfg_data[CNT_W-1:0];
                    CFG_ACROSS:  across_reg  <= cfg_data[CNT_W-1:0];
                    CFG_SIDE:    side_reg    <= cfg_data[SIDE_W-1:0];
                    CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                    default:     seed_reg    <= seed_reg;
                endcase
            end
            if (dp_cmd == OP_GEN_START)
            begin
                lcg_reg <= seed_reg;
            end
            else if (dp_cmd == OP_LCG)
            begin
                lcg_reg <= SEED_W'(lcg_reg * LCG_MUL + LCG_ADD);
            end
            if (dp_cmd == OP_RES_GEN)
            begin
                ready_reg <= 1'b1;
            end
            done_reg <= (dp_cmd == OP_RES_GEN) || (dp_cmd == OP_RES_NR) ||
                        (dp_cmd == OP_RES_OOR) || (dp_cmd == OP_RES_LOOK);
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        case (dp_cmd) inside
            OP_GEN_START:
            begin
                k_reg <= '0;
            end
            OP_LK_START:
            begin
                idx_reg <= block_index;
            end
            OP_FILL:
            begin
                k_reg <= k_reg + 1'b1;
            end
            OP_RD_J:
            begin
                tmp_reg <= mem_rdata_reg;
            end
            OP_WR_J:
            begin
                k_reg <= k_reg - 1'b1;
            end
            OP_LK_MAP:
            begin
                src_reg <= decrypt_reg ? mem_rdata_reg : idx_reg;
                dst_reg <= decrypt_reg ? idx_reg : mem_rdata_reg;
            end
            OP_SAVE_SRC:
            begin
                sx_reg <= x_prod[COORD_W-1:0];
                sy_reg <= y_prod[COORD_W-1:0];
            end
            OP_SAVE_DST:
            begin
                dx_reg <= x_prod[COORD_W-1:0];
                dy_reg <= y_prod[COORD_W-1:0];
            end
            OP_RES_LOOK:
            begin
                stat_out_reg <= STAT_OK;
                src_out_reg  <= src_reg;
                dst_out_reg  <= dst_reg;
                sx_out_reg   <= sx_reg;
                sy_out_reg   <= sy_reg;
                dx_out_reg   <= dx_reg;
                dy_out_reg   <= dy_reg;
            end
            OP_RES_GEN, OP_RES_NR, OP_RES_OOR:
            begin
                if (dp_cmd == OP_RES_NR)
                begin
                    stat_out_reg <= STAT_NOT_READY;
                end
                else if (dp_cmd == OP_RES_OOR)
                begin
                    stat_out_reg <= STAT_OUT_OF_RANGE;
                end
                else
                begin
                    stat_out_reg <= STAT_OK;
                end
                src_out_reg <= '0;
                dst_out_reg <= '0;
                sx_out_reg  <= '0;
                sy_out_reg  <= '0;
                dx_out_reg  <= '0;
                dy_out_reg  <= '0;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign done      = done_reg;
    assign status    = stat_out_reg;
    assign src_index = src_out_reg;
    assign dst_index = dst_out_reg;
    assign src_x     = sx_out_reg;
    assign src_y     = sy_out_reg;
    assign dst_x     = dx_out_reg;
    assign dst_y     = dy_out_reg;

endmodule

@@ design/sbpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// sbpm_ctrl
// Controller state machine: sequences table fill, shuffle steps and lookups,
// issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module sbpm_ctrl
    import sbpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       opcode,
    output logic       busy,
    input  dp_status_t dp_status,
    output dp_op_t     dp_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_FILL,
        S_SHUF_CHK,
        S_LCG,
        S_DIV_J,
        S_WAIT_J,
        S_RD_I,
        S_RD_J,
        S_WR_I,
        S_WR_J,
        S_RES_GEN,
        S_RES_NR,
        S_RES_OOR,
        S_LK_MAP,
        S_DIV_SRC,
        S_WAIT_SRC,
        S_DIV_DST,
        S_WAIT_DST,
        S_RES_LOOK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OPC_GENERATE)
                    begin
                        dp_cmd     = OP_GEN_START;
                        state_next = S_FILL;
                    end
                    else if (!dp_status.table_ready)
                    begin
                        state_next = S_RES_NR;
                    end
                    else if (dp_status.idx_oor)
                    begin
                        state_next = S_RES_OOR;
                    end
                    else
                    begin
                        dp_cmd     = OP_LK_START;
                        state_next = S_LK_MAP;
                    end
                end
            end
            S_FILL:
            begin
                if (dp_status.fill_done)
                begin
                    state_next = S_SHUF_CHK;
                end
                else
                begin
                    dp_cmd = OP_FILL;
                end
            end
            S_SHUF_CHK:
            begin
                state_next = dp_status.shuf_more ? S_LCG : S_RES_GEN;
            end
            S_LCG:
            begin
                dp_cmd     = OP_LCG;
                state_next = S_DIV_J;
            end
            S_DIV_J:
            begin
                dp_cmd     = OP_DIV_J;
                state_next = S_WAIT_J;
            end
            S_WAIT_J:
            begin
                if (dp_status.div_done)
                begin
                    state_next = S_RD_I;
                end
            end
            S_RD_I:
            begin
                dp_cmd     = OP_RD_I;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                dp_cmd     = OP_RD_J;
                state_next = S_WR_I;
            end
            S_WR_I:
            begin
                dp_cmd     = OP_WR_I;
                state_next = S_WR_J;
            end
            S_WR_J:
            begin
                dp_cmd     = OP_WR_J;
                state_next = S_SHUF_CHK;
            end
            S_RES_GEN:
            begin
                dp_cmd     = OP_RES_GEN;
                state_next = S_IDLE;
            end
            S_RES_NR:
            begin
                dp_cmd     = OP_RES_NR;
                state_next = S_IDLE;
            end
            S_RES_OOR:
            begin
                dp_cmd     = OP_RES_OOR;
                state_next = S_IDLE;
            end
            S_LK_MAP:
            begin
                dp_cmd     = OP_LK_MAP;
                state_next = S_DIV_SRC;
            end
            S_DIV_SRC:
            begin
                dp_cmd     = OP_DIV_SRC;
                state_next = S_WAIT_SRC;
            end
            S_WAIT_SRC:
            begin
                if (dp_status.div_done)
                begin
                    dp_cmd     = OP_SAVE_SRC;
                    state_next = S_DIV_DST;
                end
            end
            S_DIV_DST:
            begin
                dp_cmd     = OP_DIV_DST;
                state_next = S_WAIT_DST;
            end
            S_WAIT_DST:
            begin
                if (dp_status.div_done)
                begin
                    dp_cmd     = OP_SAVE_DST;
                    state_next = S_RES_LOOK;
                end
            end
            S_RES_LOOK:
            begin
                dp_cmd     = OP_RES_LOOK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy_next = (state_next != S_IDLE);

    // state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

@@ design/seeded_block_permutation_mapper.sv @@
// ----------------------------------------------------------------------------
// seeded_block_permutation_mapper
// Builds a seeded Fisher-Yates block permutation and maps block indexes to
// source/destination blocks with their top-left pixel coordinates.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  -------   -----------------------   ----------------------------------------
//  command   start && !busy            opcode, block_index
//  result    done (one-cycle strobe)   status, src_index, dst_index,
//                                      src_x, src_y, dst_x, dst_y
//  config    cfg_valid && cfg_ready    cfg_index, cfg_data
//
//  one transaction at a time; busy rises at the accept edge and falls as done
//  strobes. a lookup makes two 12-step divider passes between accept and
//  strobe; not-ready and out-of-range answers strobe from one result state.
//  a generate of n blocks makes one table write per fill cycle, then per
//  shuffle step a 31-step divide for the modulo and four single-port table
//  accesses for the swap.
//  reset clears control state and loads register defaults; the table needs
//  no clearing pass. results cannot be stalled by the receiver.
//
module seeded_block_permutation_mapper
    import sbpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  opcode,
    input  logic [IDX_W-1:0]      block_index,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [IDX_W-1:0]      src_index,
    output logic [IDX_W-1:0]      dst_index,
    output logic [COORD_W-1:0]    src_x,
    output logic [COORD_W-1:0]    src_y,
    output logic [COORD_W-1:0]    dst_x,
    output logic [COORD_W-1:0]    dst_y,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_op_t     dp_cmd;
    dp_status_t dp_status;

    // sequencer
    sbpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .busy      (busy),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    // table, lcg, divider and coordinate math
    sbpm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .dp_status   (dp_status),
        .block_index (block_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .src_index   (src_index),
        .dst_index   (dst_index),
        .src_x       (src_x),
        .src_y       (src_y),
        .dst_x       (dst_x),
        .dst_y       (dst_y)
    );

endmodule
